FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked concurrent checks used across the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on an explicit clock and reset.
`define FMIQ_CHECK_CLK(label, clk_sig, rst_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) else $error(msg);

// Check on the module's clk and rst.
`define FMIQ_CHECK(label, prop, msg) \
  `FMIQ_CHECK_CLK(label, clk, rst, prop, msg)

`endif

FILE: hw/rtl/fmiq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FM I/Q modulator package
// Widths, register indexes, output format codes and table constants.
// ----------------------------------------------------------------------------
package fmiq_pkg;

  // Field and datapath widths
  localparam int SAMPLE_W    = 16;
  localparam int ROM_W       = 23;  // sine entry in Q.22, 0..2^22
  localparam int OUT_W       = 32;
  localparam int STEP_W      = 25;
  localparam int FRAC_W      = 24;
  localparam int PHASE_W     = 32;
  localparam int FORMAT_W    = 2;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;

  // Shared multiplier operand widths
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 25;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam int unsigned ONE_FRAC = 16777216;  // 1.0 in the resample fraction
  localparam int unsigned Q22_ONE  = 4194304;   // 1.0 in Q.22

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_RESAMPLE_STEP = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_FORMAT = 2'd2;

  // Register reset values
  localparam logic [STEP_W-1:0]   RESAMPLE_STEP_RST = 25'd1912603;
  localparam logic [PHASE_W-1:0]  PHASE_STEP_RST    = 32'd161061274;
  localparam logic [FORMAT_W-1:0] OUTPUT_FORMAT_RST = 2'd2;

  // Output format codes
  localparam logic [FORMAT_W-1:0] FMT_S8  = 2'd0;
  localparam logic [FORMAT_W-1:0] FMT_U8  = 2'd1;
  localparam logic [FORMAT_W-1:0] FMT_S16 = 2'd2;
  localparam logic [FORMAT_W-1:0] FMT_F32 = 2'd3;

  // Sine series constants: pi/2 in Q.60 and the Taylor divisors (2n)(2n+1)
  localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1847;
  localparam int unsigned SERIES_TERMS = 14;
  localparam int unsigned SERIES_DIV [1:14] =
    '{6, 20, 42, 72, 110, 156, 210, 272, 342, 420, 506, 600, 702, 812};

endpackage

FILE: hw/rtl/fmiq_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FM I/Q modulator stream interfaces
// Valid/ready channels for input samples and output I/Q results.
// ----------------------------------------------------------------------------
interface fmiq_in_if
  import fmiq_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface fmiq_out_if
  import fmiq_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] i_value;
  logic [OUT_W-1:0] q_value;
  logic             last;

  modport source (output valid, output i_value, output q_value, output last, input ready);
  modport sink   (input valid, input i_value, input q_value, input last, output ready);
endinterface

FILE: hw/rtl/fmiq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module fmiq_ram #(
  parameter int WIDTH = 23,
  parameter int DEPTH = 1025
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/fmiq_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared multiplier
// Signed 33 x 25 multiply with a registered product.
// ----------------------------------------------------------------------------
module fmiq_mul
  import fmiq_pkg::*;
(
  input  logic                      clk,
  input  logic signed [MUL_A_W-1:0] a,
  input  logic signed [MUL_B_W-1:0] b,
  output logic signed [MUL_P_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= MUL_P_W'(a) * MUL_P_W'(b);
  end

endmodule

FILE: hw/rtl/fmiq_sine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quarter-wave sine store
// Fills a RAM with sin(pi/2 * j/DEPTH) in Q.22 after reset, then serves reads.
// ----------------------------------------------------------------------------
module fmiq_sine
  import fmiq_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [$clog2(DEPTH+1)-1:0]   raddr,
  output logic [ROM_W-1:0]             rdata,
  output logic                         ready
);

  localparam int AW = $clog2(DEPTH + 1);
  localparam logic [63:0] Q_STEP = HALF_PI_Q60 / DEPTH;
  localparam logic [63:0] R_STEP = HALF_PI_Q60 % DEPTH;

  // (a*b) >> 60 on 64-bit operands
  function automatic logic [63:0] mul_q60(logic [63:0] a, logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[123:60];
  endfunction

  // Series evaluation of one table entry, rounded to Q.22
  function automatic logic [ROM_W-1:0] sine_entry(int unsigned j);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] t;
    x    = Q_STEP * 64'(j) + (R_STEP * 64'(j)) / DEPTH;
    x2   = mul_q60(x, x);
    term = x;
    sum  = x;
    for (int unsigned n = 1; n <= SERIES_TERMS; n++) begin
      term = mul_q60(term, x2) / 64'(SERIES_DIV[n]);
      if (n[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    t = (sum + (64'd1 << 37)) >> 38;
    if (t > 64'(Q22_ONE)) begin
      t = 64'(Q22_ONE);
    end
    return t[ROM_W-1:0];
  endfunction

  logic [ROM_W-1:0] init_rom [DEPTH+1];

  for (genvar j = 0; j <= DEPTH; j++) begin : g_init
    localparam logic [ROM_W-1:0] ENTRY = sine_entry(j);
    assign init_rom[j] = ENTRY;
  end

  logic          filling;
  logic [AW-1:0] fill_addr;

  // Sweep every entry once after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      filling   <= 1'b1;
      fill_addr <= '0;
    end else if (filling) begin
      if (fill_addr == AW'(DEPTH)) begin
        filling <= 1'b0;
      end else begin
        fill_addr <= fill_addr + AW'(1);
      end
    end
  end

  assign ready = !filling;

  fmiq_ram #(
    .WIDTH (ROM_W),
    .DEPTH (DEPTH + 1)
  ) u_ram (
    .clk   (clk),
    .we    (filling),
    .waddr (fill_addr),
    .wdata (init_rom[fill_addr]),
    .raddr (raddr),
    .rdata (rdata)
  );

endmodule

FILE: hw/rtl/fm_iq_modulator_resampler.sv
`timescale 1ns / 1ps
// Sequencing: each result steps through MUL_I, SUM, MUL_P, PHASE, MUL_X, IDX, RD_B,
//   SEL, MUL_S, FIN and PUSH (one multiplier, five passes); PUSH waits for the output.
// Runs: 1..MAX_OUTPUTS_PER_INPUT results per sample; no sample is taken mid-run.
// Reset: synchronous; config registers load defaults, interpolator and carrier
//   state clear, then the sine RAM fills all SINE_TABLE_DEPTH+1 entries with no
//   sample taken meanwhile (config writes still land).
// ----------------------------------------------------------------------------
// FM I/Q modulator with linear-interpolation resampler
// Upsamples Q2.14 samples, advances an FM carrier phase and emits cos/sin
// pairs from a quarter-wave sine table in one of four encodings.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fm_iq_modulator_resampler
  import fmiq_pkg::*;
#(
  parameter int SINE_TABLE_DEPTH      = 1024,
  parameter int MAX_OUTPUTS_PER_INPUT = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  fmiq_in_if.sink                samples,
  fmiq_out_if.source             results,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int KW    = $clog2(SINE_TABLE_DEPTH);
  localparam int AW    = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int IDX_W = $clog2(4 * SINE_TABLE_DEPTH);
  localparam int CNT_W = (MAX_OUTPUTS_PER_INPUT > 1) ? $clog2(MAX_OUTPUTS_PER_INPUT) : 1;
  localparam int unsigned MIN_STEP =
    (ONE_FRAC + MAX_OUTPUTS_PER_INPUT - 1) / MAX_OUTPUTS_PER_INPUT;
  localparam logic [IDX_W-1:0] D1 = IDX_W'(SINE_TABLE_DEPTH);
  localparam logic [IDX_W-1:0] D2 = IDX_W'(2 * SINE_TABLE_DEPTH);
  localparam logic [IDX_W-1:0] D3 = IDX_W'(3 * SINE_TABLE_DEPTH);
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,   // wait for a sample request
    S_MUL_I,  // frac * (cur - prev)
    S_SUM,    // form interpolated value
    S_MUL_P,  // phase_step * interpolated value
    S_PHASE,  // advance carrier and fraction
    S_MUL_X,  // carrier * 4 * DEPTH
    S_IDX,    // split table index, read first entry
    S_RD_B,   // read mirrored entry
    S_SEL,    // quadrant symmetry, encode cos
    S_MUL_S,  // encode sin
    S_FIN,    // finish sin word
    S_PUSH    // hand the pair to the output register
  } state_t;

  // --------------------------------------------------------------------------
  // Encoding helpers
  // --------------------------------------------------------------------------
  function automatic logic signed [MUL_A_W-1:0] enc_operand(logic [FORMAT_W-1:0] fmt,
                                                            logic signed [23:0] t);
    logic signed [24:0] biased;
    logic        [22:0] mag;
    biased = 25'(t) + 25'(Q22_ONE);
    mag    = t[23] ? 23'(-t) : t[22:0];
    if (fmt == FMT_U8) begin
      return MUL_A_W'(biased);
    end
    return MUL_A_W'({1'b0, mag});
  endfunction

  function automatic logic signed [MUL_B_W-1:0] enc_factor(logic [FORMAT_W-1:0] fmt);
    logic signed [MUL_B_W-1:0] f;
    unique case (fmt)
      FMT_S8:  f = MUL_B_W'(127);
      FMT_U8:  f = MUL_B_W'(255);
      FMT_S16: f = MUL_B_W'(32767);
      default: f = '0;
    endcase
    return f;
  endfunction

  function automatic logic [OUT_W-1:0] enc_word(logic [FORMAT_W-1:0] fmt,
                                                logic signed [23:0] t,
                                                logic signed [MUL_P_W-1:0] prod);
    logic [22:0]      mag;
    logic [4:0]       pos;
    logic [7:0]       expo;
    logic [31:0]      shifted;
    logic [OUT_W-1:0] v;
    logic [OUT_W-1:0] w;
    mag = t[23] ? 23'(-t) : t[22:0];
    pos = '0;
    for (int b = 0; b < 23; b++) begin
      if (mag[b]) begin
        pos = 5'(b);
      end
    end
    expo    = 8'(pos) + 8'd105;
    shifted = 32'(mag) << (5'd23 - pos);
    unique case (fmt) inside
      FMT_S8, FMT_S16: begin
        v = prod[53:22];
        w = t[23] ? (OUT_W'(0) - v) : v;
      end
      FMT_U8: begin
        w = prod[54:23];
      end
      default: begin
        w = (mag == '0) ? '0 : {t[23], expo, shifted[22:0]};
      end
    endcase
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  state_t                      state;
  logic [STEP_W-1:0]           resample_step;
  logic [PHASE_W-1:0]          phase_step;
  logic [FORMAT_W-1:0]         output_format;
  logic signed [SAMPLE_W-1:0]  previous_sample;
  logic [FRAC_W-1:0]           resample_fraction;
  logic [PHASE_W-1:0]          carrier_phase;
  logic signed [SAMPLE_W-1:0]  cur_sample;
  logic signed [23:0]          interp;
  logic [CNT_W-1:0]            out_cnt;
  logic                        last_flag;
  logic [KW-1:0]               k_reg;
  logic [1:0]                  quad_reg;
  logic [ROM_W-1:0]            sin_a;
  logic signed [23:0]          cos_val;
  logic signed [23:0]          sin_val;
  logic [OUT_W-1:0]            i_word;
  logic [OUT_W-1:0]            q_word;
  logic                        out_valid;
  logic [OUT_W-1:0]            out_i;
  logic [OUT_W-1:0]            out_q;
  logic                        out_last;

  // Datapath nets
  logic                        fill_done;
  logic [AW-1:0]               rom_addr;
  logic [ROM_W-1:0]            rom_data;
  logic signed [MUL_A_W-1:0]   mul_a;
  logic signed [MUL_B_W-1:0]   mul_b;
  logic signed [MUL_P_W-1:0]   mul_p;
  logic [STEP_W-1:0]           step_sat;
  logic [STEP_W-1:0]           frac_sum;
  logic                        run_done;
  logic signed [16:0]          diff;
  logic [41:0]                 acc;
  logic [IDX_W-1:0]            idx;
  logic [KW-1:0]               k_next;
  logic [1:0]                  quad_next;
  logic signed [23:0]          a_ext;
  logic signed [23:0]          b_ext;
  logic signed [23:0]          cos_next;
  logic signed [23:0]          sin_next;
  logic                        push_ok;
  logic                        push_at_cap;
  logic                        push_last;

  // Clamp the step so every sample yields 1..MAX_OUTPUTS_PER_INPUT results
  always_comb begin
    if (resample_step < STEP_W'(MIN_STEP)) begin
      step_sat = STEP_W'(MIN_STEP);
    end else if (resample_step > STEP_W'(ONE_FRAC)) begin
      step_sat = STEP_W'(ONE_FRAC);
    end else begin
      step_sat = resample_step;
    end
  end

  // Fraction crossing 1.0 consumes the sample; the output cap forces it too
  assign frac_sum = {1'b0, resample_fraction} + step_sat;
  assign run_done = frac_sum[FRAC_W] || (out_cnt == CNT_W'(MAX_OUTPUTS_PER_INPUT - 1));

  // Interpolation: prev*2^24 + frac*(cur-prev), then floor by 2^16
  assign diff = 17'(cur_sample) - 17'(previous_sample);
  assign acc  = {{2{previous_sample[SAMPLE_W-1]}}, previous_sample, 24'd0} + mul_p[41:0];

  // Table index split into quadrant and offset
  assign idx = mul_p[32 +: IDX_W];

  always_comb begin
    if (idx >= D3) begin
      quad_next = QUAD_3;
      k_next    = KW'(idx - D3);
    end else if (idx >= D2) begin
      quad_next = QUAD_2;
      k_next    = KW'(idx - D2);
    end else if (idx >= D1) begin
      quad_next = QUAD_1;
      k_next    = KW'(idx - D1);
    end else begin
      quad_next = QUAD_0;
      k_next    = KW'(idx);
    end
  end

  // Quadrant symmetry: a = sin table at k, b = sin table at DEPTH-k
  assign a_ext = 24'({1'b0, sin_a});
  assign b_ext = 24'({1'b0, rom_data});

  always_comb begin
    case (quad_reg)
      QUAD_0: begin
        sin_next = a_ext;
        cos_next = b_ext;
      end
      QUAD_1: begin
        sin_next = b_ext;
        cos_next = -a_ext;
      end
      QUAD_2: begin
        sin_next = -a_ext;
        cos_next = -b_ext;
      end
      default: begin
        sin_next = -b_ext;
        cos_next = a_ext;
      end
    endcase
  end

  // Operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_MUL_I: begin
        mul_a = MUL_A_W'({1'b0, resample_fraction});
        mul_b = MUL_B_W'(diff);
      end
      S_MUL_P: begin
        mul_a = MUL_A_W'({1'b0, phase_step});
        mul_b = MUL_B_W'(interp);
      end
      S_MUL_X: begin
        mul_a = MUL_A_W'({1'b0, carrier_phase});
        mul_b = MUL_B_W'(4 * SINE_TABLE_DEPTH);
      end
      S_SEL: begin
        mul_a = enc_operand(output_format, cos_next);
        mul_b = enc_factor(output_format);
      end
      S_MUL_S: begin
        mul_a = enc_operand(output_format, sin_val);
        mul_b = enc_factor(output_format);
      end
      default: begin
      end
    endcase
  end

  // Table read address: offset first, mirrored offset next
  always_comb begin
    case (state)
      S_IDX:   rom_addr = AW'(k_next);
      S_RD_B:  rom_addr = AW'(SINE_TABLE_DEPTH) - AW'(k_reg);
      default: rom_addr = '0;
    endcase
  end

  assign push_ok     = !out_valid || results.ready;
  assign push_at_cap = (state == S_PUSH) && (out_cnt == CNT_W'(MAX_OUTPUTS_PER_INPUT - 1));
  assign push_last   = (state == S_PUSH) && push_ok && last_flag;

  fmiq_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  fmiq_sine #(
    .DEPTH (SINE_TABLE_DEPTH)
  ) u_sine (
    .clk   (clk),
    .rst   (rst),
    .raddr (rom_addr),
    .rdata (rom_data),
    .ready (fill_done)
  );

  // --------------------------------------------------------------------------
  // Sequencer, config registers and output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      resample_step     <= RESAMPLE_STEP_RST;
      phase_step        <= PHASE_STEP_RST;
      output_format     <= OUTPUT_FORMAT_RST;
      previous_sample   <= '0;
      resample_fraction <= '0;
      carrier_phase     <= '0;
      out_cnt           <= '0;
      last_flag         <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      // Config writes; indexes past the list drop
      if (cfg_write) begin
        unique case (cfg_index)
          REG_RESAMPLE_STEP: resample_step <= cfg_data[STEP_W-1:0];
          REG_PHASE_STEP:    phase_step    <= cfg_data[PHASE_W-1:0];
          REG_OUTPUT_FORMAT: output_format <= cfg_data[FORMAT_W-1:0];
          default: begin
          end
        endcase
      end

      // Retire the held result once the sink takes the request; in the push
      // step the next pair takes its place instead
      if (out_valid && results.ready && (state != S_PUSH)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (samples.valid && fill_done) begin
            cur_sample <= samples.sample;
            out_cnt    <= '0;
            state      <= S_MUL_I;
          end
        end
        S_MUL_I: begin
          state <= S_SUM;
        end
        S_SUM: begin
          interp <= acc[39:16];
          state  <= S_MUL_P;
        end
        S_MUL_P: begin
          state <= S_PHASE;
        end
        S_PHASE: begin
          // Advance carrier mod one turn, step the fraction, end the run on crossing or cap
          carrier_phase     <= carrier_phase + mul_p[53:22];
          resample_fraction <= frac_sum[FRAC_W-1:0];
          last_flag         <= run_done;
          if (run_done) begin
            previous_sample <= cur_sample;
          end
          state <= S_MUL_X;
        end
        S_MUL_X: begin
          state <= S_IDX;
        end
        S_IDX: begin
          k_reg    <= k_next;
          quad_reg <= quad_next;
          state    <= S_RD_B;
        end
        S_RD_B: begin
          sin_a <= rom_data;
          state <= S_SEL;
        end
        S_SEL: begin
          cos_val <= cos_next;
          sin_val <= sin_next;
          state   <= S_MUL_S;
        end
        S_MUL_S: begin
          i_word <= enc_word(output_format, cos_val, mul_p);
          state  <= S_FIN;
        end
        S_FIN: begin
          q_word <= enc_word(output_format, sin_val, mul_p);
          state  <= S_PUSH;
        end
        S_PUSH: begin
          // Hold until the output register is free
          if (push_ok) begin
            out_valid <= 1'b1;
            out_i     <= i_word;
            out_q     <= q_word;
            out_last  <= last_flag;
            if (last_flag) begin
              state <= S_IDLE;
            end else begin
              out_cnt <= out_cnt + CNT_W'(1);
              state   <= S_MUL_I;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign samples.ready   = (state == S_IDLE) && fill_done;
  assign results.valid   = out_valid;
  assign results.i_value = out_i;
  assign results.q_value = out_q;
  assign results.last    = out_last;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `FMIQ_CHECK(a_cap_forces_last, push_at_cap |-> last_flag, "cap reached without last")
  `FMIQ_CHECK(a_carrier_hold, (state != S_PHASE) |=> $stable(carrier_phase), "carrier jumped")
  `FMIQ_CHECK(a_last_to_idle, push_last |=> (state == S_IDLE) && results.last, "run did not end")

endmodule

FILE: verif/fm_iq_modulator_resampler_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FM I/Q modulator resampler testbench
// Streams Q2.14 samples through the modulator under random flow control and
// checks every cos/sin request against a bit-exact predictor of the
// interpolator, carrier phase, quarter-wave sine lookup and output encodings.
// ----------------------------------------------------------------------------
module fm_iq_modulator_resampler_test
  import fmiq_pkg::*;
();

  localparam int SINE_DEPTH  = 1024;
  localparam int MAX_OUTPUTS = 64;
  localparam int unsigned MIN_STEP = (ONE_FRAC + MAX_OUTPUTS - 1) / MAX_OUTPUTS;
  localparam longint unsigned HALF_PI_FIX = 64'h1921FB54442D1847;
  localparam int IDLE_LIMIT = 4000;
  localparam int RANDOM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 25;

  // Index 3 decodes to no register; writes there must not disturb anything.
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [OUT_W-1:0] i_value;
    logic [OUT_W-1:0] q_value;
    logic             last;
  } iq_pair_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  fmiq_in_if  samples_if ();
  fmiq_out_if results_if ();

  fm_iq_modulator_resampler dut (
    .clk       (clk),
    .rst       (rst),
    .samples   (samples_if),
    .results   (results_if),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow of the modulator: register copies plus interpolator and carrier state.
  logic [STEP_W-1:0]          cfg_step;
  logic [PHASE_W-1:0]         cfg_phase_step;
  logic [FORMAT_W-1:0]        cfg_format;
  logic signed [SAMPLE_W-1:0] held_sample;
  logic [FRAC_W-1:0]          frac_acc;
  logic [PHASE_W-1:0]         phase_acc;
  int unsigned                quarter_sine [0:SINE_DEPTH];

  iq_pair_t expected_iq [$];
  int       mismatch_count;
  int       burst_left;
  int       stall_left;
  int       open_left;
  bit       choppy;
  logic signed [SAMPLE_W-1:0] last_sent;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // (a * b) >> 60 with the full 128-bit product.
  function automatic longint unsigned q60_product(longint unsigned a, longint unsigned b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  // Fill the quarter-wave table: Taylor series of sin through x^29 in Q.60,
  // rounded half-up into Q.22 and capped at 1.0.
  function automatic void build_quarter_sine();
    longint unsigned step_q, step_r, x, x2, term, sum, t;
    step_q = HALF_PI_FIX / SINE_DEPTH;
    step_r = HALF_PI_FIX % SINE_DEPTH;
    for (int j = 0; j <= SINE_DEPTH; j++) begin
      x    = step_q * j + (step_r * j) / SINE_DEPTH;
      x2   = q60_product(x, x);
      term = x;
      sum  = x;
      for (int n = 1; n <= 14; n++) begin
        term = q60_product(term, x2) / longint'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) sum = sum - term;
        else sum = sum + term;
      end
      t = (sum + (64'd1 << 37)) >> 38;
      if (t > Q22_ONE) t = Q22_ONE;
      quarter_sine[j] = int'(t);
    end
  endfunction

  // Encode a Q.22 value per the current output format; truncate toward zero.
  function automatic logic [OUT_W-1:0] encode_level(int signed level);
    int unsigned mag;
    int signed   biased;
    int          p;
    logic [31:0] v;
    mag = (level < 0) ? -level : level;
    v = '0;
    case (cfg_format)
      FMT_S8: begin
        v = 32'(({32'd0, mag} * 64'd127) >> 22);
        v = (level < 0) ? -v : v;
      end
      FMT_U8: begin
        biased = level + int'(Q22_ONE);
        v = 32'(({32'd0, 32'(biased)} * 64'd255) >> 23);
      end
      FMT_S16: begin
        v = 32'(({32'd0, mag} * 64'd32767) >> 22);
        v = (level < 0) ? -v : v;
      end
      FMT_F32: begin
        // Zero always encodes as +0.
        if (mag != 0) begin
          p = 22;
          while (mag[p] == 1'b0) p--;
          v = (32'(p + 105) << 23) | ((mag << (23 - p)) & 32'h007F_FFFF);
          if (level < 0) v[31] = 1'b1;
        end
      end
    endcase
    return v;
  endfunction

  // Produce the whole run of cos/sin pairs that one sample causes.
  function automatic void modulate_sample(logic signed [SAMPLE_W-1:0] cur);
    longint signed   acc, level, delta;
    longint unsigned scaled;
    int unsigned     step, idx, quad, k, frac_next;
    int signed       a, b, s, c;
    int              n;
    bit              done;
    iq_pair_t        pair;
    // Saturate the step so a sample always yields 1..MAX_OUTPUTS pairs.
    step = cfg_step;
    if (step < MIN_STEP) step = MIN_STEP;
    if (step > ONE_FRAC) step = ONE_FRAC;
    n = 0;
    done = 1'b0;
    while (!done) begin
      acc = longint'(held_sample) * longint'(ONE_FRAC)
          + $signed({40'd0, frac_acc}) * (longint'(cur) - longint'(held_sample));
      level = acc >>> 16;
      delta = ($signed({32'd0, cfg_phase_step}) * level) >>> 22;
      phase_acc = phase_acc + delta[31:0];
      scaled = {32'd0, phase_acc} * (4 * SINE_DEPTH);
      idx  = int'(scaled >> 32);
      quad = idx / SINE_DEPTH;
      k    = idx % SINE_DEPTH;
      a = quarter_sine[k];
      b = quarter_sine[SINE_DEPTH - k];
      case (quad % 4)
        0: begin s = a;  c = b;  end
        1: begin s = b;  c = -a; end
        2: begin s = -a; c = -b; end
        default: begin s = -b; c = a; end
      endcase
      // Consume the sample once the fraction wraps; the cap forces it too.
      frac_next = frac_acc + step;
      if (frac_next >= ONE_FRAC || n == MAX_OUTPUTS - 1) begin
        frac_next = frac_next % ONE_FRAC;
        held_sample = cur;
        done = 1'b1;
      end
      frac_acc = frac_next[FRAC_W-1:0];
      pair.i_value = encode_level(c);
      pair.q_value = encode_level(s);
      pair.last    = done;
      expected_iq.push_back(pair);
      n++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Monitors and checking
  // --------------------------------------------------------------------------

  // Predict at the edge where a sample request is taken.
  always @(posedge clk) begin
    if (!rst && samples_if.valid === 1'b1 && samples_if.ready === 1'b1)
      modulate_sample(samples_if.sample);
  end

  function automatic void note_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("[%0t] %s: expected %h, got %h", $realtime, what, want, got);
  endfunction

  // Compare each result request with the oldest pending pair.
  always @(posedge clk) begin
    iq_pair_t want;
    if (!rst && results_if.valid === 1'b1 && results_if.ready === 1'b1) begin
      if (expected_iq.size() == 0) begin
        note_mismatch("unexpected i_value", '0, results_if.i_value);
      end else begin
        want = expected_iq.pop_front();
        if (results_if.i_value !== want.i_value)
          note_mismatch("i_value", want.i_value, results_if.i_value);
        if (results_if.q_value !== want.q_value)
          note_mismatch("q_value", want.q_value, results_if.q_value);
        if (results_if.last !== want.last)
          note_mismatch("last", 32'(want.last), 32'(results_if.last));
      end
    end
  end

  // Receiver: stall for a while, then open up, sometimes choppy, sometimes solid.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      results_if.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (open_left != 0) begin
      results_if.ready <= choppy ? ($urandom_range(0, 2) != 0) : 1'b1;
      open_left <= open_left - 1;
    end else begin
      results_if.ready <= 1'b1;
      open_left  <= $urandom_range(0, 80);
      stall_left <= $urandom_range(0, 24);
      choppy     <= ($urandom_range(0, 2) == 0);
    end
  end

  // Watchdog: end the run if no request moves on either channel for too long.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (samples_if.valid === 1'b1 && samples_if.ready === 1'b1) ||
          (results_if.valid === 1'b1 && results_if.ready === 1'b1))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus tasks
  // --------------------------------------------------------------------------

  // Hold one sample request until it is taken; keep valid up for a burst.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
    samples_if.valid  <= 1'b1;
    samples_if.sample <= value;
    do @(posedge clk); while (samples_if.ready !== 1'b1);
    last_sent = value;
    // Drop valid between bursts; long bursts give stretches with no gaps.
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      samples_if.valid <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40)
                                                : $urandom_range(0, 6);
    end
  endtask

  // Hold off the sender until every pending pair has come back.
  task automatic drain_results();
    samples_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_iq.size() != 0) @(posedge clk);
  endtask

  // Write one register while the block is idle and mirror it in the shadow.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      REG_RESAMPLE_STEP: cfg_step       = value[STEP_W-1:0];
      REG_PHASE_STEP:    cfg_phase_step = value[PHASE_W-1:0];
      REG_OUTPUT_FORMAT: cfg_format     = value[FORMAT_W-1:0];
      default: ;  // no register behind this index
    endcase
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int signed stepped;
    case ($urandom_range(0, 9))
      0: return ($urandom_range(0, 1) == 0) ? 16'sh7FFF : 16'sh8000;
      1, 2, 3: return 16'($urandom());
      default: begin
        // Smooth walk from the last sample, like a real multiplex signal.
        stepped = int'(last_sent) + $urandom_range(0, 4000) - 2000;
        if (stepped > 32767) stepped = 32767;
        if (stepped < -32768) stepped = -32768;
        return 16'(stepped);
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Right after reset the carrier sits at zero: silent input keeps it there,
  // so sin is exactly zero and must encode as +0.
  task automatic test_zero_carrier();
    write_reg(REG_OUTPUT_FORMAT, {30'd0, FMT_F32});
    send_sample(16'sd0);
    send_sample(16'sd0);
    drain_results();
  endtask

  // Full-scale swings with the reset rate and deviation.
  task automatic test_sample_extremes();
    write_reg(REG_OUTPUT_FORMAT, {30'd0, FMT_S16});
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh8000);
    send_sample(16'sd1);
    send_sample(-16'sd1);
    drain_results();
  endtask

  task automatic test_output_formats();
    logic [FORMAT_W-1:0] fmts [4];
    fmts = '{FMT_S8, FMT_U8, FMT_S16, FMT_F32};
    foreach (fmts[f]) begin
      write_reg(REG_OUTPUT_FORMAT, {30'd0, fmts[f]});
      send_sample(16'($urandom()));
      send_sample(16'($urandom()));
      drain_results();
    end
  endtask

  // Out-of-range steps saturate: low steps give at most the 64-pair cap, high ones one pair.
  // The forced-last path at the cap cannot be reached once the step is saturated.
  task automatic test_step_saturation();
    logic [31:0] steps [6];
    steps = '{32'd0, MIN_STEP - 1, MIN_STEP, ONE_FRAC, ONE_FRAC + 1, 32'h01FF_FFFF};
    foreach (steps[i]) begin
      write_reg(REG_RESAMPLE_STEP, steps[i]);
      send_sample(16'($urandom()));
      drain_results();
    end
    write_reg(REG_RESAMPLE_STEP, {7'd0, RESAMPLE_STEP_RST});
  endtask

  task automatic test_phase_step();
    logic [31:0] devs [3];
    devs = '{32'd0, 32'hFFFF_FFFF, 32'h8000_0000};
    foreach (devs[i]) begin
      write_reg(REG_PHASE_STEP, devs[i]);
      send_sample(($urandom_range(0, 1) == 0) ? 16'sh7FFF : 16'sh8000);
      drain_results();
    end
  endtask

  // A write to the unused index must leave every register as it was.
  task automatic test_unused_index();
    write_reg(REG_UNUSED, $urandom());
    send_sample(16'($urandom()));
    drain_results();
  endtask

  // Random configurations, each followed by a stream of mostly smooth samples.
  task automatic test_random_streams();
    logic [31:0] step_word;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case ($urandom_range(0, 4))
        0: step_word = $urandom();                          // any 25 bits after masking
        1: step_word = $urandom_range(MIN_STEP, 1000000);   // long runs
        default: step_word = $urandom_range(1000000, ONE_FRAC);
      endcase
      write_reg(REG_RESAMPLE_STEP, step_word);
      write_reg(REG_PHASE_STEP, ($urandom_range(0, 3) == 0) ? $urandom()
                                                            : $urandom_range(0, 32'h8000_0000));
      // Walk every format across the phases; keep the unused data bits random.
      write_reg(REG_OUTPUT_FORMAT, ($urandom() & ~32'd3) | 32'(ph % 4));
      if ($urandom_range(0, 2) == 0) write_reg(REG_UNUSED, $urandom());
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Pause mid-phase until the pipe is empty, then resume.
        if (n == ITEMS_PER_PHASE / 2) drain_results();
        send_sample(pick_sample());
      end
      drain_results();
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    // Drive every input to a known value from time zero; the receiver owns ready.
    rst               <= 1'b1;
    cfg_write         <= 1'b0;
    cfg_index         <= REG_RESAMPLE_STEP;
    cfg_data          <= '0;
    samples_if.valid  <= 1'b0;
    samples_if.sample <= '0;
    mismatch_count = 0;
    burst_left     = 0;
    last_sent      = '0;
    build_quarter_sine();
    cfg_step       = RESAMPLE_STEP_RST;
    cfg_phase_step = PHASE_STEP_RST;
    cfg_format     = OUTPUT_FORMAT_RST;
    held_sample    = '0;
    frac_acc       = '0;
    phase_acc      = '0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The sine RAM fill after reset simply holds off the first sample request.
    test_zero_carrier();
    test_sample_extremes();
    test_output_formats();
    test_step_saturation();
    test_phase_step();
    test_unused_index();
    test_random_streams();

    drain_results();
    // Let any stray result surface before judging.
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && expected_iq.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/fmiq_pkg.sv
hw/rtl/fmiq_if.sv
hw/rtl/fmiq_ram.sv
hw/rtl/fmiq_mul.sv
hw/rtl/fmiq_sine.sv
hw/rtl/fm_iq_modulator_resampler.sv
verif/fm_iq_modulator_resampler_test.sv
